### rtl/dsq_pkg.sv
// package for the derandomizer slot queue
// holds payload structs, state enum, register indexes and constants; no dependencies
package dsq_pkg;

  localparam int unsigned QueueDepthDef = 32;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] PeriodRst = 32'd100000;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_SLOT_PERIOD  = 1'b0,
    REG_BUFFER_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        opcode;
    logic [47:0] event_time;
    logic [47:0] life_time;
    logic [31:0] event_id;
  } in_item_t;

  typedef struct packed {
    logic        is_lost;
    logic [47:0] out_time;
    logic [47:0] out_life_time;
    logic [31:0] out_event_id;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [47:0] t;
    logic [47:0] life;
    logic [31:0] id;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DECIDE,
    ST_MOD,
    ST_EMIT,
    ST_PUSH,
    ST_LSMOD,
    ST_FLUSH,
    ST_CLEAR
  } state_t;

endpackage

### rtl/dsq_mod.sv
// sequential 48-bit by 32-bit remainder unit, one quotient bit per cycle
// depends on nothing outside itself
module dsq_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic [31:0] rem_r, rem_nxt;
  logic [47:0] sh_r, sh_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    rem_nxt = rem_r;
    sh_nxt = sh_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dv_nxt = dv_r;
    trial = {rem_r, sh_r[47]};
    diff = trial - {1'b0, dv_r};
    if (start) begin
      rem_nxt = '0;
      sh_nxt = dividend;
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
      dv_nxt = divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so 32 bits hold it
      if (trial >= {1'b0, dv_r}) rem_nxt = diff[31:0];
      else rem_nxt = trial[31:0];
      sh_nxt = {sh_r[46:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r <= sh_nxt;
    dv_r <= dv_nxt;
  end

  assign done = done_r;
  assign rem = rem_r;

endmodule

### rtl/derandomizer_slot_queue.sv
// derandomizer slot queue top level: queue memory, sequencer, config port
// depends on dsq_pkg and dsq_mod
//
// usage:
//  - in_ channel takes one transaction per item: an event (opcode 0) or a flush
//    (opcode 1); out_ channel delivers results, last marks the final one of an item
//  - an event first releases waiting entries onto free slots before its time,
//    then drops the oldest as lost if the queue is at its limit, then is queued
//  - a flush releases entries up to the slot at or after the latest event time,
//    reports the rest as lost and returns the state to reset
//  - each slot realignment runs one pass of the bit-serial remainder unit, and
//    a flush adds one more remainder pass on the latest event time
//  - one item is worked on at a time; in_stall is high while busy
//  - a result waits in the output register while out_stall is high; the
//    sequencer holds until it is taken
//  - reset clears control state; queue memory contents are not cleared, only
//    entries written since the last reset or flush are ever read
//  - cfg_ registers must be written while idle (the block does not enforce it); prdata returns their values
module derandomizer_slot_queue #(
  parameter int unsigned QUEUE_DEPTH = dsq_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dsq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dsq_pkg::out_item_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [31:0] period_r;
  logic [5:0]  limit_r;
  logic        cfg_wr;
  dsq_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'b00);
  assign cfg_idx = dsq_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= dsq_pkg::PeriodRst;
      limit_r <= 6'd32;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dsq_pkg::REG_SLOT_PERIOD:  period_r <= cfg_pwdata;
        dsq_pkg::REG_BUFFER_LIMIT: limit_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsq_pkg::REG_SLOT_PERIOD: cfg_prdata = period_r;
      default:                  cfg_prdata = {26'd0, limit_r};
    endcase
  end

  // effective period and limit
  logic [31:0] eff_period;
  logic [CW-1:0] eff_limit;
  assign eff_period = (period_r == 32'd0) ? 32'd1 : period_r;
  always_comb begin
    if (limit_r == 6'd0) eff_limit = CW'(1);
    else if (32'(limit_r) > QUEUE_DEPTH) eff_limit = CW'(QUEUE_DEPTH);
    else eff_limit = CW'(limit_r);
  end

  // queue memory
  dsq_pkg::entry_t mem [QUEUE_DEPTH];
  dsq_pkg::entry_t rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  dsq_pkg::entry_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // sequencer state
  dsq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [47:0] slot_r, slot_nxt;
  logic [47:0] latest_r, latest_nxt;
  logic [47:0] lastslot_r, lastslot_nxt;
  dsq_pkg::in_item_t item_r, item_nxt;
  logic emitted_r, emitted_nxt;
  logic outv_r, outv_nxt;
  dsq_pkg::out_item_t outd_r, outd_nxt;
  logic pend_r, pend_nxt;
  dsq_pkg::out_item_t pendd_r;

  // remainder unit
  logic        mod_start, mod_done;
  logic [47:0] mod_in;
  logic [31:0] mod_rem;
  logic [48:0] up_sum;
  logic [47:0] up_val, slot_inc;
  logic [48:0] inc_sum;

  dsq_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mod_in),
    .divisor(eff_period), .done(mod_done), .rem(mod_rem)
  );

  // round the divided value up to the next slot, saturating
  always_comb begin
    up_sum = {1'b0, mod_in} + 49'(eff_period - mod_rem);
    if (mod_rem == 32'd0) up_val = mod_in;
    else if (up_sum > {1'b0, dsq_pkg::Max48}) up_val = dsq_pkg::Max48;
    else up_val = up_sum[47:0];
    inc_sum = {1'b0, slot_r} + 49'(eff_period);
    slot_inc = (inc_sum > {1'b0, dsq_pkg::Max48}) ? dsq_pkg::Max48 : inc_sum[47:0];
  end

  logic out_free;
  logic [AW-1:0] head_inc;
  logic [CW:0]   tail_sum;
  assign out_free = !outv_r || !out_stall;
  assign head_inc = (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + AW'(1);
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
  end

  assign in_stall = (state_r != dsq_pkg::ST_IDLE);
  // the flush pass starts in idle and runs in lsmod on the latest event time
  assign mod_in = (state_r == dsq_pkg::ST_IDLE || state_r == dsq_pkg::ST_LSMOD) ?
                  latest_r : rd_q.t;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    count_nxt = count_r;
    slot_nxt = slot_r;
    latest_nxt = latest_r;
    lastslot_nxt = lastslot_r;
    item_nxt = item_r;
    emitted_nxt = emitted_r;
    outv_nxt = outv_r && out_stall;
    outd_nxt = outd_r;
    mem_we = 1'b0;
    mem_waddr = tail_sum[AW-1:0];
    mem_wdata = {item_r.event_time, item_r.life_time, item_r.event_id};
    mem_raddr = head_r;
    mod_start = 1'b0;
    case (state_r)
      dsq_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          emitted_nxt = 1'b0;
          if (in_data.opcode == dsq_pkg::OP_FLUSH) begin
            mod_start = 1'b1;
            state_nxt = dsq_pkg::ST_LSMOD;
          end else begin
            state_nxt = dsq_pkg::ST_CHECK;
          end
        end
      end
      dsq_pkg::ST_LSMOD: begin
        if (mod_done) begin
          lastslot_nxt = up_val;
          state_nxt = dsq_pkg::ST_CHECK;
        end
      end
      dsq_pkg::ST_CHECK: begin
        // decide whether another drain step runs
        if (count_r != '0 &&
            ((item_r.opcode == dsq_pkg::OP_EVENT && slot_r < item_r.event_time) ||
             (item_r.opcode == dsq_pkg::OP_FLUSH && slot_r <= lastslot_r)))
          state_nxt = dsq_pkg::ST_READ;
        else if (item_r.opcode == dsq_pkg::OP_FLUSH)
          state_nxt = dsq_pkg::ST_FLUSH;
        else if (count_r >= eff_limit)
          state_nxt = dsq_pkg::ST_EMIT;
        else
          state_nxt = dsq_pkg::ST_PUSH;
        if (state_nxt == dsq_pkg::ST_FLUSH || state_nxt == dsq_pkg::ST_EMIT)
          state_nxt = dsq_pkg::ST_CLEAR; // read head first
      end
      dsq_pkg::ST_READ: begin
        state_nxt = dsq_pkg::ST_DECIDE;
      end
      dsq_pkg::ST_DECIDE: begin
        if (rd_q.t <= slot_r) begin
          if (out_free) begin
            outv_nxt = 1'b1;
            outd_nxt = {1'b0, slot_r, rd_q.life, rd_q.id, 1'b0};
            emitted_nxt = 1'b1;
            head_nxt = head_inc;
            count_nxt = count_r - CW'(1);
            slot_nxt = slot_inc;
            state_nxt = dsq_pkg::ST_CHECK;
          end
        end else begin
          mod_start = 1'b1;
          state_nxt = dsq_pkg::ST_MOD;
        end
      end
      dsq_pkg::ST_MOD: begin
        if (mod_done) begin
          slot_nxt = up_val;
          state_nxt = dsq_pkg::ST_CHECK;
        end
      end
      dsq_pkg::ST_CLEAR: begin
        // head read issued, lost report follows
        state_nxt = (item_r.opcode == dsq_pkg::OP_FLUSH) ? dsq_pkg::ST_FLUSH
                                                          : dsq_pkg::ST_EMIT;
      end
      dsq_pkg::ST_EMIT: begin
        // drop oldest at limit
        if (out_free) begin
          outv_nxt = 1'b1;
          outd_nxt = {1'b1, rd_q.t, rd_q.life, rd_q.id, 1'b0};
          emitted_nxt = 1'b1;
          head_nxt = head_inc;
          count_nxt = count_r - CW'(1);
          state_nxt = dsq_pkg::ST_PUSH;
        end
      end
      dsq_pkg::ST_PUSH: begin
        if (out_free) begin
          mem_we = 1'b1;
          count_nxt = count_r + CW'(1);
          latest_nxt = item_r.event_time;
          if (emitted_r) begin
            // parked result is the final one of this transaction
            outv_nxt = 1'b1;
            outd_nxt = pendd_r;
            outd_nxt.last = 1'b1;
          end
          state_nxt = dsq_pkg::ST_IDLE;
        end
      end
      dsq_pkg::ST_FLUSH: begin
        if (count_r != '0) begin
          if (out_free) begin
            outv_nxt = 1'b1;
            outd_nxt = {1'b1, rd_q.t, rd_q.life, rd_q.id, 1'b0};
            emitted_nxt = 1'b1;
            head_nxt = head_inc;
            count_nxt = count_r - CW'(1);
            state_nxt = dsq_pkg::ST_CLEAR;
          end
        end else if (out_free) begin
          if (emitted_r) begin
            outv_nxt = 1'b1;
            outd_nxt = pendd_r;
            outd_nxt.last = 1'b1;
          end
          head_nxt = '0;
          slot_nxt = '0;
          latest_nxt = '0;
          state_nxt = dsq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dsq_pkg::ST_IDLE;
    endcase
  end

  // results are held one step: the previous result goes out when the next
  // is known, so the final one can carry last
  always_comb begin
    pend_nxt = pend_r;
    if (outv_nxt && !(outv_r && out_stall) && !outd_nxt.last) pend_nxt = 1'b1;
    if (outv_nxt && outd_nxt.last) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsq_pkg::ST_IDLE;
      head_r <= '0;
      count_r <= '0;
      slot_r <= '0;
      latest_r <= '0;
      emitted_r <= 1'b0;
      pend_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      slot_r <= slot_nxt;
      latest_r <= latest_nxt;
      emitted_r <= emitted_nxt;
      pend_r <= pend_nxt;
      // a new result first parks in the pending slot; the parked one leaves
      if (outv_nxt && !(outv_r && out_stall)) outv_r <= pend_r || outd_nxt.last;
      else if (!out_stall) outv_r <= 1'b0;
    end
    lastslot_r <= lastslot_nxt;
    item_r <= item_nxt;
    if (outv_nxt && !(outv_r && out_stall)) begin
      pendd_r <= outd_nxt;
      outd_r <= outd_nxt.last ? outd_nxt : pendd_r;
    end
  end

  assign out_valid = outv_r;
  assign out_data = outd_r;

`ifndef SYNTH
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QUEUE_DEPTH) else $error("queue count over depth");
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsq_pkg::ST_IDLE) |-> !in_stall) else $error("stall while idle");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsq_pkg::ST_FLUSH && count_r == '0 && out_free) |=>
    (slot_r == '0 && count_r == '0)) else $error("flush left state");
`endif

endmodule
